FILE: hw/rtl/lcdr_pkg.sv
`default_nettype none

package lcdr_pkg;

    localparam int ROWS_DEF = 4;
    localparam int COLS_DEF = 20;
    localparam int MAX_ROWS = 8;

    localparam int ROW_W  = 3;
    localparam int COL_W  = 5;
    localparam int CHAR_W = 8;

    localparam logic [CHAR_W-1:0] PAD_CHAR = 8'h20;
    localparam logic [CHAR_W-1:0] NUL_CHAR = 8'h00;

    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_CHAR = 1'b1;

    localparam logic KIND_CURSOR = 1'b0;
    localparam logic KIND_WRITE  = 1'b1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic              action;
        logic [ROW_W-1:0]  row;
        logic [CHAR_W-1:0] character;
    } cmd_t;

    typedef struct packed {
        logic              kind;
        logic [ROW_W-1:0]  row_res;
        logic [CHAR_W-1:0] character_res;
    } lcd_t;

    typedef struct packed {
        logic              is_char;
        logic [ROW_W-1:0]  row;
        logic              in_range;
        logic [COL_W-1:0]  col;
        logic              first;
        logic              last;
        logic [CHAR_W-1:0] value;
    } op_t;

    typedef enum logic [2:0] {
        RF_IDLE   = 3'b001,
        RF_CURSOR = 3'b010,
        RF_WRITE  = 3'b100
    } rf_state_t;

    typedef struct packed {
        rf_state_t           state;
        logic [MAX_ROWS-1:0] dirty;
        logic [ROW_W-1:0]    rf_row;
        logic                emit_cursor;
    } back_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/lcdr_front.sv
`default_nettype none

module lcdr_front #(
    parameter int ROWS = lcdr_pkg::ROWS_DEF,
    parameter int COLS = lcdr_pkg::COLS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    output logic               cmd_ready,
    input  wire lcdr_pkg::cmd_t cmd,
    output logic               op_valid,
    input  wire logic          op_ready,
    output lcdr_pkg::op_t      op
);

    logic [lcdr_pkg::COL_W-1:0] stg_col_reg, stg_col_next;
    logic [lcdr_pkg::ROW_W-1:0] stg_row_reg, stg_row_next;
    logic                       ended_reg, ended_next;

    logic                       first;
    logic                       last;
    logic                       pad;
    logic [lcdr_pkg::ROW_W-1:0] row_eff;
    logic                       accept;

    assign cmd_ready = op_ready;
    assign op_valid  = cmd_valid;
    assign accept    = cmd_valid && cmd_ready && (cmd.action == lcdr_pkg::ACT_CHAR);

    always_comb
    begin
        first   = (stg_col_reg == '0);
        last    = (stg_col_reg == lcdr_pkg::COL_W'(COLS - 1));
        row_eff = first ? cmd.row : stg_row_reg;
        pad     = (!first && ended_reg) || (cmd.character == lcdr_pkg::NUL_CHAR);

        op = '0;
        if (cmd.action == lcdr_pkg::ACT_CHAR)
        begin
            op.is_char  = 1'b1;
            op.row      = row_eff;
            op.in_range = (32'(row_eff) < ROWS);
            op.col      = stg_col_reg;
            op.first    = first;
            op.last     = last;
            op.value    = pad ? lcdr_pkg::PAD_CHAR : cmd.character;
        end

        stg_col_next = stg_col_reg;
        stg_row_next = stg_row_reg;
        ended_next   = ended_reg;
        if (accept)
        begin
            stg_col_next = last ? '0 : stg_col_reg + 1'b1;
            stg_row_next = row_eff;
            ended_next   = pad;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_col_reg <= '0;
            stg_row_reg <= '0;
            ended_reg   <= 1'b0;
        end
        else
        begin
            stg_col_reg <= stg_col_next;
            stg_row_reg <= stg_row_next;
            ended_reg   <= ended_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/lcdr_queue.sv
`default_nettype none

module lcdr_queue (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               push_valid,
    output logic                                    push_ready,
    input  wire lcdr_pkg::op_t                      push_op,
    output logic                                    pop_valid,
    input  wire logic                               pop_ready,
    output lcdr_pkg::op_t                           pop_op,
    output logic [lcdr_pkg::QUEUE_CNT_W-1:0]        count
);

    localparam int PW = $clog2(lcdr_pkg::QUEUE_DEPTH);

    lcdr_pkg::op_t                   slot_reg [lcdr_pkg::QUEUE_DEPTH];
    logic [PW-1:0]                   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]                   rd_ptr_reg, rd_ptr_next;
    logic [lcdr_pkg::QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                            push;
    logic                            pop;

    assign push_ready = (count_reg != lcdr_pkg::QUEUE_CNT_W'(lcdr_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_op     = slot_reg[rd_ptr_reg];
    assign count      = count_reg;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/lcdr_back.sv
`default_nettype none

module lcdr_back #(
    parameter int ROWS = lcdr_pkg::ROWS_DEF,
    parameter int COLS = lcdr_pkg::COLS_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             op_valid,
    output logic                  op_ready,
    input  wire lcdr_pkg::op_t    op,
    output logic                  lcd_valid,
    input  wire logic             lcd_ready,
    output lcdr_pkg::lcd_t        lcd,
    output lcdr_pkg::back_stat_t  stat
);

    localparam int NWORDS = 2 * ROWS * COLS;
    localparam int AW     = $clog2(NWORDS);
    localparam int RIW    = (ROWS > 1) ? $clog2(ROWS) : 1;

    function automatic logic [AW-1:0] word_addr(
        input logic                       bank,
        input logic [lcdr_pkg::ROW_W-1:0] row,
        input logic [lcdr_pkg::COL_W-1:0] col
    );
        int unsigned a;
        a = (32'(bank) * ROWS + 32'(row)) * COLS + 32'(col);
        return AW'(a);
    endfunction

    function automatic logic [RIW-1:0] row_idx(input logic [lcdr_pkg::ROW_W-1:0] row);
        return (32'(row) < ROWS) ? row[RIW-1:0] : '0;
    endfunction

    // screen store: two banks per row, the live one picked by bank_reg
    logic [lcdr_pkg::CHAR_W-1:0] mem [NWORDS];

    logic                        ex_valid_reg, ex_valid_next;
    lcdr_pkg::op_t               ex_op_reg, ex_op_next;
    logic [ROWS-1:0]             bank_reg, bank_next;
    logic [ROWS-1:0]             rowval_reg, rowval_next;
    logic [ROWS-1:0]             dirty_reg, dirty_next;
    lcdr_pkg::rf_state_t         state_reg, state_next;
    logic [lcdr_pkg::ROW_W-1:0]  rf_row_reg, rf_row_next;
    logic [lcdr_pkg::COL_W-1:0]  rf_col_reg, rf_col_next;
    logic                        differs_reg, differs_next;
    logic [lcdr_pkg::CHAR_W-1:0] q_reg;
    logic                        rd_valid_reg, rd_valid_next;
    logic                        byp_hit_reg, byp_hit_next;
    logic [lcdr_pkg::CHAR_W-1:0] byp_data_reg;
    logic                        out_valid_reg;
    lcdr_pkg::lcd_t              out_reg;

    logic                        pick_found;
    logic [lcdr_pkg::ROW_W-1:0]  pick_row;
    logic                        produces;
    logic                        fire;
    logic [lcdr_pkg::CHAR_W-1:0] rd_byte;
    lcdr_pkg::lcd_t              res;
    logic                        we;
    logic [AW-1:0]               waddr;
    logic [AW-1:0]               raddr;
    logic [lcdr_pkg::ROW_W-1:0]  rb_row;
    logic [lcdr_pkg::COL_W-1:0]  rb_col;
    logic [RIW-1:0]              ex_ri;
    logic [RIW-1:0]              rb_ri;
    logic                        diff;

    assign rd_byte  = byp_hit_reg ? byp_data_reg : (rd_valid_reg ? q_reg : lcdr_pkg::NUL_CHAR);
    assign produces = ex_valid_reg && !ex_op_reg.is_char &&
                      ((state_reg == lcdr_pkg::RF_CURSOR) || (state_reg == lcdr_pkg::RF_WRITE));
    assign fire     = !produces || !out_valid_reg || lcd_ready;
    assign op_ready = fire;
    assign lcd_valid = out_valid_reg;
    assign lcd       = out_reg;

    always_comb
    begin
        pick_found = 1'b0;
        pick_row   = '0;
        for (int r = ROWS - 1; r >= 0; r--)
        begin
            if (dirty_reg[r])
            begin
                pick_found = 1'b1;
                pick_row   = lcdr_pkg::ROW_W'(r);
            end
        end
    end

    always_comb
    begin
        bank_next    = bank_reg;
        rowval_next  = rowval_reg;
        dirty_next   = dirty_reg;
        state_next   = state_reg;
        rf_row_next  = rf_row_reg;
        rf_col_next  = rf_col_reg;
        differs_next = differs_reg;
        res          = '0;
        we           = 1'b0;
        waddr        = '0;
        diff         = 1'b0;
        ex_ri        = row_idx(ex_op_reg.row);

        if (ex_valid_reg && ex_op_reg.is_char && ex_op_reg.in_range)
        begin
            diff         = (!ex_op_reg.first && differs_reg) || (rd_byte != ex_op_reg.value);
            differs_next = diff;
            we           = fire;
            waddr        = word_addr(!bank_reg[ex_ri], ex_op_reg.row, ex_op_reg.col);
            if (ex_op_reg.last && diff)
            begin
                bank_next[ex_ri]   = !bank_reg[ex_ri];
                rowval_next[ex_ri] = 1'b1;
                dirty_next[ex_ri]  = 1'b1;
            end
        end
        else if (ex_valid_reg && !ex_op_reg.is_char)
        begin
            unique case (state_reg)
                lcdr_pkg::RF_IDLE:
                begin
                    if (pick_found)
                    begin
                        rf_row_next = pick_row;
                        rf_col_next = '0;
                        state_next  = lcdr_pkg::RF_CURSOR;
                    end
                end
                lcdr_pkg::RF_CURSOR:
                begin
                    res.kind    = lcdr_pkg::KIND_CURSOR;
                    res.row_res = rf_row_reg;
                    state_next  = lcdr_pkg::RF_WRITE;
                end
                lcdr_pkg::RF_WRITE:
                begin
                    res.kind          = lcdr_pkg::KIND_WRITE;
                    res.character_res = rd_byte;
                    if (rf_col_reg == lcdr_pkg::COL_W'(COLS - 1))
                    begin
                        dirty_next[row_idx(rf_row_reg)] = 1'b0;
                        rf_col_next = '0;
                        state_next  = lcdr_pkg::RF_IDLE;
                    end
                    else
                    begin
                        rf_col_next = rf_col_reg + 1'b1;
                    end
                end
                default:
                begin
                    state_next = lcdr_pkg::RF_IDLE;
                end
            endcase
        end

        // read for the next op sees the state this op leaves
        ex_valid_next = op_valid;
        ex_op_next    = op;
        rb_row        = op.is_char ? op.row : rf_row_next;
        rb_col        = op.is_char ? op.col : rf_col_next;
        rb_ri         = row_idx(rb_row);
        raddr         = word_addr(bank_next[rb_ri], rb_row, rb_col);
        rd_valid_next = rowval_next[rb_ri];
        byp_hit_next  = we && (waddr == raddr);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ex_valid_reg <= 1'b0;
            bank_reg     <= '0;
            rowval_reg   <= '0;
            dirty_reg    <= '0;
            state_reg    <= lcdr_pkg::RF_IDLE;
            rf_row_reg   <= '0;
            rf_col_reg   <= '0;
            differs_reg  <= 1'b0;
            rd_valid_reg <= 1'b0;
            byp_hit_reg  <= 1'b0;
        end
        else if (fire)
        begin
            ex_valid_reg <= ex_valid_next;
            bank_reg     <= bank_next;
            rowval_reg   <= rowval_next;
            dirty_reg    <= dirty_next;
            state_reg    <= state_next;
            rf_row_reg   <= rf_row_next;
            rf_col_reg   <= rf_col_next;
            differs_reg  <= differs_next;
            rd_valid_reg <= rd_valid_next;
            byp_hit_reg  <= byp_hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            ex_op_reg    <= ex_op_next;
            byp_data_reg <= ex_op_reg.value;
            q_reg        <= mem[raddr];
        end
        if (we)
        begin
            mem[waddr] <= ex_op_reg.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            priority if (fire && produces)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (lcd_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= out_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && produces)
        begin
            out_reg <= res;
        end
    end

    always_comb
    begin
        stat             = '0;
        stat.state       = state_reg;
        stat.dirty       = lcdr_pkg::MAX_ROWS'(dirty_reg);
        stat.rf_row      = rf_row_reg;
        stat.emit_cursor = fire && produces && (state_reg == lcdr_pkg::RF_CURSOR);
    end

endmodule

`default_nettype wire

FILE: hw/rtl/char_lcd_dirty_row_refresh.sv
// character lcd refresh controller with per-row dirty marks
// cmd channel (valid/ready): one transaction is either a refresh tick (action 0)
//   or one character of a line write (action 1); a line is exactly COLS
//   transactions and takes its row from the first one
// lcd channel (valid/ready): set-cursor (kind 0, row_res) or write-character
//   (kind 1, character_res) transactions, at most one per tick
// throughput: one cmd transaction per cycle unless lcd stalls, set by the single
//   execute stage that does one store read and one store write per cycle
// a tick's result passes through a queue slot, the execute stage and the lcd output register
// a two-entry queue sits between the cmd front end and the execute stage;
//   when lcd stalls with a result pending and the executing tick has another
//   result, execution holds and cmd_ready drops once the queue is full
// reset: screen store reads as all zero, dirty marks clear, refresh idle;
//   no clearing pass, per-row valid bits cover the store
// a line that differs from the stored row is staged into the row's spare bank
//   and the banks swap on its last column
`default_nettype none

module char_lcd_dirty_row_refresh #(
    parameter int ROWS = lcdr_pkg::ROWS_DEF,
    parameter int COLS = lcdr_pkg::COLS_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cmd_valid,
    output logic                cmd_ready,
    input  wire lcdr_pkg::cmd_t cmd,
    output logic                lcd_valid,
    input  wire logic           lcd_ready,
    output lcdr_pkg::lcd_t      lcd
);

    logic                                 fe_valid;
    logic                                 fe_ready;
    lcdr_pkg::op_t                        fe_op;
    logic                                 be_valid;
    logic                                 be_ready;
    lcdr_pkg::op_t                        be_op;
    logic [lcdr_pkg::QUEUE_CNT_W-1:0]     q_count;
    lcdr_pkg::back_stat_t                 stat;

    lcdr_front #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .op_valid  (fe_valid),
        .op_ready  (fe_ready),
        .op        (fe_op)
    );

    lcdr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fe_valid),
        .push_ready (fe_ready),
        .push_op    (fe_op),
        .pop_valid  (be_valid),
        .pop_ready  (be_ready),
        .pop_op     (be_op),
        .count      (q_count)
    );

    lcdr_back #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (be_valid),
        .op_ready  (be_ready),
        .op        (be_op),
        .lcd_valid (lcd_valid),
        .lcd_ready (lcd_ready),
        .lcd       (lcd),
        .stat      (stat)
    );

    a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> q_count != '0)
        else $error("queue empty after an accepted transaction");

    a_cursor_row_dirty: assert property (@(posedge clk) disable iff (!rst_n)
        stat.state == lcdr_pkg::RF_CURSOR |-> stat.dirty[stat.rf_row])
        else $error("refresh row not dirty while issuing cursor");

    a_cursor_emit: assert property (@(posedge clk) disable iff (!rst_n)
        stat.emit_cursor |=> lcd_valid && lcd.kind == lcdr_pkg::KIND_CURSOR &&
                             stat.state == lcdr_pkg::RF_WRITE)
        else $error("cursor result not presented or refresh not in write");

endmodule

`default_nettype wire
